FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks on a clock and an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the cycle after it
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/core/evd_pkg.sv
// ----------------------------------------------------------------------------
// evd_pkg
// types, codes and helpers shared by the event dispatcher files
// ----------------------------------------------------------------------------
package evd_pkg;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int BIT_W      = 5;
    localparam int PORT_W     = 6;
    localparam int OP_W       = 2;

    typedef logic [OP_W-1:0] t_opcode;

    localparam t_opcode OP_UNMASK   = 2'd0;
    localparam t_opcode OP_RAISE    = 2'd1;
    localparam t_opcode OP_DISPATCH = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic unmask;
        logic raise;
        logic start;
        logic take;
        logic next_word;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic word_hit;
        logic last_word;
        logic have_hold;
        logic slot_free;
    } t_status;

    // index of the lowest set bit, zero when none
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/evd_ifs.sv
// ----------------------------------------------------------------------------
// evd interfaces
// valid/ready channels for operation requests and dispatched ports
// ----------------------------------------------------------------------------
interface evd_in_if;
    import evd_pkg::*;

    logic              valid;
    logic              ready;
    t_opcode           opcode;
    logic [PORT_W-1:0] port;

    modport source (output valid, output opcode, output port, input ready);
    modport sink   (input valid, input opcode, input port, output ready);
endinterface

interface evd_out_if;
    import evd_pkg::*;

    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] port_out;
    logic              last;

    modport source (output valid, output port_out, output last, input ready);
    modport sink   (input valid, input port_out, input last, output ready);
endinterface

FILE: rtl/core/evd_dpath.sv
// ----------------------------------------------------------------------------
// evd_dpath
// pending/mask bitmaps, word selector, walk pointer and output register
// ----------------------------------------------------------------------------
module evd_dpath #(
    parameter int PORTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  evd_pkg::t_cmd              i_cmd,
    input  logic [evd_pkg::PORT_W-1:0] i_port,
    output evd_pkg::t_status           o_status,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [evd_pkg::PORT_W-1:0] o_out_port,
    output logic                       o_out_last
);
    import evd_pkg::*;

    localparam int WORDS  = (PORTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [WORD_BITS-1:0] r_pend [WORDS];
    logic [WORD_BITS-1:0] r_mask [WORDS];
    logic [WORDS-1:0]     r_sel;
    logic [WORDS-1:0]     r_walk;
    logic [WIDX_W-1:0]    r_widx;
    logic                 r_hold_valid;
    logic [PORT_W-1:0]    r_hold_port;
    logic                 r_out_valid;
    logic [PORT_W-1:0]    r_out_port;
    logic                 r_out_last;

    logic                 w_port_ok;
    logic [WIDX_W-1:0]    w_in_word;
    logic [BIT_W-1:0]     w_in_bit;
    logic [WORD_BITS-1:0] w_ready;
    logic [BIT_W-1:0]     w_bi;

    assign w_port_ok = ({{(32 - PORT_W){1'b0}}, i_port} < 32'(PORTS));
    assign w_in_word = WIDX_W'(i_port >> WORD_SHIFT);
    assign w_in_bit  = i_port[BIT_W-1:0];

    // ports of the walked word that are pending and unmasked
    assign w_ready = r_pend[r_widx] & ~r_mask[r_widx];
    assign w_bi    = lowest_bit(w_ready);

    assign o_status.word_hit  = r_walk[r_widx] && (w_ready != '0);
    assign o_status.last_word = (r_widx == WIDX_W'(WORDS - 1));
    assign o_status.have_hold = r_hold_valid;
    assign o_status.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) begin
                r_pend[i] <= '0;
                r_mask[i] <= '1;
            end
            r_sel        <= '0;
            r_walk       <= '0;
            r_widx       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // load the output register, else drain it on a handshake
            if ((i_cmd.take && r_hold_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.unmask && w_port_ok) begin
                r_mask[w_in_word][w_in_bit] <= 1'b0;
            end
            if (i_cmd.raise && w_port_ok) begin
                r_pend[w_in_word][w_in_bit] <= 1'b1;
                r_sel[w_in_word]            <= 1'b1;
            end
            if (i_cmd.start) begin
                r_walk       <= r_sel;
                r_sel        <= '0;
                r_widx       <= '0;
                r_hold_valid <= 1'b0;
            end
            if (i_cmd.take) begin
                r_pend[r_widx][w_bi] <= 1'b0;
                r_hold_valid         <= 1'b1;
            end
            if (i_cmd.next_word) begin
                r_widx <= WIDX_W'(r_widx + 1'b1);
            end
            if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_hold_port <= {r_widx[0], w_bi};
            if (r_hold_valid) begin
                r_out_port <= r_hold_port;
                r_out_last <= 1'b0;
            end
        end
        if (i_cmd.flush) begin
            r_out_port <= r_hold_port;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_port  = r_out_port;
    assign o_out_last  = r_out_last;

endmodule

FILE: rtl/core/evd_ctrl.sv
// ----------------------------------------------------------------------------
// evd_ctrl
// sequencer for operation decode and the dispatch walk
// ----------------------------------------------------------------------------
module evd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  evd_pkg::t_opcode i_opcode,
    output logic             o_in_ready,
    input  evd_pkg::t_status i_status,
    output evd_pkg::t_cmd    o_cmd
);
    import evd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == OP_UNMASK) begin
                        o_cmd.unmask = 1'b1;
                    end else if (i_opcode == OP_RAISE) begin
                        o_cmd.raise = 1'b1;
                    end else if (i_opcode == OP_DISPATCH) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.slot_free) begin
                    priority if (i_status.word_hit) begin
                        o_cmd.take = 1'b1;
                    end else if (i_status.last_word) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.next_word = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.have_hold) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/event_channel_dispatcher.sv
// ----------------------------------------------------------------------------
// event_channel_dispatcher
// event ports with pending/mask bitmaps and a per-word selector
// ----------------------------------------------------------------------------
// unmask and raise: a new transaction every cycle while idle, no result
// dispatch: input held off while the walk steps through every word and takes
//   each pending, unmasked port of the selected words in turn, the last port
//   leaving with the last flag; output stalls pause the walk and stretch it
// reset: synchronous, all ports masked, pending bits and selector cleared at once
module event_channel_dispatcher #(
    parameter int PORTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    evd_in_if.sink           i_evt,
    evd_out_if.source        o_evt
);
    import evd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // controller: decodes transactions and sequences the walk
    evd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .i_opcode   (i_evt.opcode),
        .o_in_ready (i_evt.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath: bitmaps, priority encoder, one-deep hold for the last flag,
    // and the output register that decouples the sink
    evd_dpath #(
        .PORTS (PORTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_port      (i_evt.port),
        .o_status    (w_status),
        .i_out_ready (o_evt.ready),
        .o_out_valid (o_evt.valid),
        .o_out_port  (o_evt.port_out),
        .o_out_last  (o_evt.last)
    );

endmodule

FILE: rtl/core/evd_checker.sv
// ----------------------------------------------------------------------------
// evd_checker
// port-level checks on the event dispatcher, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module evd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input evd_pkg::t_opcode           i_opcode,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [evd_pkg::PORT_W-1:0] i_port_out,
    input logic                       i_last
);
    import evd_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_port_out) && $stable(i_last))

    // dispatch walk holds off the input
    `ASSERT_NEXT(a_dispatch_busy, i_clk, i_rst_n, w_in_acc && (i_opcode == OP_DISPATCH), !i_in_ready)

    // bitmap updates never produce a result
    `ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, w_in_acc && (i_opcode != OP_DISPATCH) && !i_out_valid, !i_out_valid)

    // output register empty right after reset
    `ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

endmodule

bind event_channel_dispatcher evd_checker u_evd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_opcode    (i_evt.opcode),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_port_out  (o_evt.port_out),
    .i_last      (o_evt.last)
);
